FILE: hw/rtl/dvf_pkg.sv
`default_nettype none
package dvf_pkg;

    // store geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // word field widths
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 6;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_COMPARE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic ready;    // input word may be taken
        logic step;     // read next entry, advance scan index
        logic compare;  // registered entry is valid for compare
        logic finish;   // load result, update store
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;  // store empty
        logic match;     // registered entry equals item value
        logic scan_end;  // every filled entry has been read
        logic out_free;  // output register can take a result
    } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dvf_ctrl.sv
`default_nettype none
module dvf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire dvf_pkg::status_t status,
    output dvf_pkg::cmd_t         cmd
);

    dvf_pkg::state_t state_reg;
    dvf_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dvf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dvf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.cnt_zero ? dvf_pkg::ST_DONE : dvf_pkg::ST_FETCH;
                end
            end
            dvf_pkg::ST_FETCH:
            begin
                state_next = dvf_pkg::ST_COMPARE;
            end
            dvf_pkg::ST_COMPARE:
            begin
                if (status.match || status.scan_end)
                begin
                    state_next = dvf_pkg::ST_DONE;
                end
            end
            dvf_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = dvf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dvf_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            dvf_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            dvf_pkg::ST_FETCH:
            begin
                cmd.step = 1'b1;
            end
            dvf_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                cmd.step    = !status.match && !status.scan_end;
            end
            dvf_pkg::ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dvf_datapath.sv
`default_nettype none
module dvf_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dvf_pkg::cmd_t                       cmd,
    output dvf_pkg::status_t                         status,
    input  wire logic                                in_valid,
    input  wire logic [dvf_pkg::VALUE_W-1:0]         in_value,
    input  wire logic                                in_last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [dvf_pkg::VALUE_W-1:0]              out_value,
    output logic [dvf_pkg::SLOT_W-1:0]               out_slot,
    output logic                                     out_is_new,
    output logic                                     out_overflow,
    output logic                                     out_last
);

    // value store
    logic [dvf_pkg::VALUE_W-1:0] mem [dvf_pkg::CAPACITY];
    logic [dvf_pkg::VALUE_W-1:0] rd_reg;

    // item and scan state
    logic [dvf_pkg::VALUE_W-1:0] value_reg;
    logic                        last_reg;
    logic [dvf_pkg::CNT_W-1:0]   count_reg;
    logic [dvf_pkg::CNT_W-1:0]   count_next;
    logic [dvf_pkg::CNT_W-1:0]   scan_reg;
    logic                        found_reg;
    logic [dvf_pkg::IDX_W-1:0]   pos_reg;

    // output register
    logic                        ovalid_reg;
    logic [dvf_pkg::VALUE_W-1:0] ovalue_reg;
    logic [dvf_pkg::SLOT_W-1:0]  oslot_reg;
    logic                        onew_reg;
    logic                        oovf_reg;
    logic                        olast_reg;

    logic                        load;
    logic                        full;
    logic                        store_new;
    logic [dvf_pkg::SLOT_W-1:0]  slot_result;

    assign load      = cmd.ready && in_valid;
    assign full      = (count_reg == dvf_pkg::CNT_W'(dvf_pkg::CAPACITY));
    assign store_new = cmd.finish && !found_reg && !full;

    // status back to the controller
    assign status.cnt_zero = (count_reg == '0);
    assign status.match    = (rd_reg == value_reg);
    assign status.scan_end = (scan_reg == count_reg);
    assign status.out_free = !ovalid_reg || out_ready;

    // slot reported for the finished item
    always_comb
    begin
        if (found_reg)
        begin
            slot_result = dvf_pkg::SLOT_W'(pos_reg);
        end
        else if (full)
        begin
            slot_result = '0;
        end
        else
        begin
            slot_result = dvf_pkg::SLOT_W'(count_reg[dvf_pkg::IDX_W-1:0]);
        end
    end

    // count update at the end of an item
    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish)
        begin
            if (last_reg)
            begin
                count_next = '0;
            end
            else if (store_new)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // store write and scan read
    always_ff @(posedge clk)
    begin
        if (store_new)
        begin
            mem[count_reg[dvf_pkg::IDX_W-1:0]] <= value_reg;
        end
        if (cmd.step)
        begin
            rd_reg <= mem[scan_reg[dvf_pkg::IDX_W-1:0]];
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
        if (cmd.compare && status.match)
        begin
            pos_reg <= dvf_pkg::IDX_W'(scan_reg - 1'b1);
        end
        if (cmd.finish)
        begin
            ovalue_reg <= value_reg;
            oslot_reg  <= slot_result;
            onew_reg   <= !found_reg;
            oovf_reg   <= !found_reg && full;
            olast_reg  <= last_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scan_reg   <= '0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (load)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (cmd.compare && status.match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_value    = ovalue_reg;
    assign out_slot     = oslot_reg;
    assign out_is_new   = onew_reg;
    assign out_overflow = oovf_reg;
    assign out_last     = olast_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/distinct_value_filter_top.sv
// Distinct value filter: passes a stream of signed 32-bit values and tags each
// word as new or repeated against a store of up to 64 distinct values.
// Input channel s_*: tdata carries the value, tlast marks the end of a list.
// Output channel m_*: one word per input word; tdata carries the value and the
// slot where it was stored or found, tuser carries the new and overflow flags,
// tlast copies the input tlast. A new value arriving with the store full is
// not stored and comes out with overflow set and slot zero.
// The store is scanned one entry per cycle from a single-port memory. A word taken
// with an empty store goes straight to the output register; otherwise the scan
// stops at the first match or after the last stored entry, and the result then
// moves to the output register once that register is free. The next word is taken
// in the cycle after the result has moved to the output register.
// After a word with tlast the store empties and a new list begins.
// Reset empties the store and the output register; no clearing pass is needed.
// When the receiver stalls, the finished result holds in the output register;
// a second result waits inside the block and the input stops taking words.
`default_nettype none
module distinct_value_filter_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [dvf_pkg::IN_TDATA_W-1:0]       s_tdata,   // [31:0] value
    input  wire logic                                 s_tlast,   // last_item
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [dvf_pkg::OUT_TDATA_W-1:0]           m_tdata,   // [31:0] echo_value, [37:32] slot_index, [39:38] zero
    output logic [dvf_pkg::OUT_TUSER_W-1:0]           m_tuser,   // [0] is_new, [1] overflow
    output logic                                      m_tlast    // end_of_list
);

    dvf_pkg::cmd_t    cmd;
    dvf_pkg::status_t status;

    logic [dvf_pkg::VALUE_W-1:0] out_value;
    logic [dvf_pkg::SLOT_W-1:0]  out_slot;
    logic                        out_is_new;
    logic                        out_overflow;

    // controller
    dvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    dvf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_valid     (s_tvalid),
        .in_value     (s_tdata[dvf_pkg::VALUE_W-1:0]),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (out_value),
        .out_slot     (out_slot),
        .out_is_new   (out_is_new),
        .out_overflow (out_overflow),
        .out_last     (m_tlast)
    );

    assign s_tready = cmd.ready;

    // pack output word
    assign m_tdata = {{(dvf_pkg::OUT_TDATA_W - dvf_pkg::VALUE_W - dvf_pkg::SLOT_W){1'b0}},
                      out_slot, out_value};
    assign m_tuser = {out_overflow, out_is_new};

endmodule
`default_nettype wire

FILE: dv/distinct_value_filter_checker.sv
`default_nettype none
module distinct_value_filter_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [dvf_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] value
    input  wire logic                             s_tlast,   // last_item
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [dvf_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [31:0] echo_value, [37:32] slot_index, [39:38] zero
    input  wire logic [dvf_pkg::OUT_TUSER_W-1:0]  m_tuser,   // [0] is_new, [1] overflow
    input  wire logic                             m_tlast,   // end_of_list
    output int                                    fail_count,
    output int                                    pending
);

    localparam int REPORT_MAX = 10;

    // one output word as the block should present it
    typedef struct packed {
        logic [1:0]                     pad;
        logic [dvf_pkg::SLOT_W-1:0]     slot;
        logic [dvf_pkg::VALUE_W-1:0]    value;
        logic                           ovf;
        logic                           is_new;
        logic                           eol;
    } filter_word_t;

    // shadow copy of the distinct value store
    logic [dvf_pkg::VALUE_W-1:0] seen_values [dvf_pkg::CAPACITY];
    int                          seen_count;

    filter_word_t expected_words [$];
    filter_word_t want;
    filter_word_t got;
    int           mismatch_total;
    int           report_count;

    // look the value up, append it if unseen and the store has room, clear the store after a last word
    task automatic filter_value(
        input  logic [dvf_pkg::VALUE_W-1:0] value,
        input  logic                        last,
        output filter_word_t                word
    );
        int hit;
        begin
            hit = -1;
            for (int i = 0; i < seen_count; i++)
            begin
                if (hit < 0 && seen_values[i] == value)
                begin
                    hit = i;
                end
            end
            word.pad    = '0;
            word.value  = value;
            word.eol    = last;
            word.ovf    = 1'b0;
            word.is_new = 1'b0;
            word.slot   = '0;
            if (hit >= 0)
            begin
                word.slot = hit[dvf_pkg::SLOT_W-1:0];
            end
            else
            begin
                word.is_new = 1'b1;
                if (seen_count < dvf_pkg::CAPACITY)
                begin
                    word.slot = seen_count[dvf_pkg::SLOT_W-1:0];
                    seen_values[seen_count] = value;
                    seen_count++;
                end
                else
                begin
                    // store full: value dropped
                    word.ovf = 1'b1;
                end
            end
            if (last)
            begin
                seen_count = 0;
            end
        end
    endtask

    // predict on accepted input words, compare accepted output words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            seen_count     = 0;
            mismatch_total = 0;
            report_count   = 0;
            fail_count     <= 0;
            pending        <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                filter_value(s_tdata[dvf_pkg::VALUE_W-1:0], s_tlast, want);
                expected_words.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.pad    = m_tdata[39:38];
                got.slot   = m_tdata[37:32];
                got.value  = m_tdata[31:0];
                got.ovf    = m_tuser[1];
                got.is_new = m_tuser[0];
                got.eol    = m_tlast;
                if (expected_words.size() == 0)
                begin
                    mismatch_total++;
                    if (report_count < REPORT_MAX)
                    begin
                        $display("unexpected output word: value=%h slot=%0d new=%0b ovf=%0b last=%0b",
                                 got.value, got.slot, got.is_new, got.ovf, got.eol);
                    end
                    report_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.pad !== want.pad || got.slot !== want.slot ||
                        got.value !== want.value || got.ovf !== want.ovf ||
                        got.is_new !== want.is_new || got.eol !== want.eol)
                    begin
                        mismatch_total++;
                        if (report_count < REPORT_MAX)
                        begin
                            $display("mismatch: expected value=%h slot=%0d new=%0b ovf=%0b last=%0b pad=%0h",
                                     want.value, want.slot, want.is_new, want.ovf, want.eol, want.pad);
                            $display("          actual   value=%h slot=%0d new=%0b ovf=%0b last=%0b pad=%0h",
                                     got.value, got.slot, got.is_new, got.ovf, got.eol, got.pad);
                        end
                        report_count++;
                    end
                end
            end
            fail_count <= mismatch_total;
            pending    <= expected_words.size();
        end
    end

endmodule
`default_nettype wire

FILE: dv/tb_distinct_value_filter_top.sv
`default_nettype none
module tb_distinct_value_filter_top;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = dvf_pkg::CAPACITY + 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 600;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic [dvf_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;   // [31:0] value
    logic                             s_tlast  = 1'b0; // last_item
    logic                             m_tready = 1'b0;
    logic                             s_tready;
    logic                             m_tvalid;
    logic [dvf_pkg::OUT_TDATA_W-1:0]  m_tdata;         // [31:0] echo_value, [37:32] slot_index, [39:38] zero
    logic [dvf_pkg::OUT_TUSER_W-1:0]  m_tuser;         // [0] is_new, [1] overflow
    logic                             m_tlast;         // end_of_list

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int sent_count   = 0;
    bit idle_en      = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    distinct_value_filter_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    distinct_value_filter_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("** distinct_value_filter_top: FAILED **");
            $finish;
        end
    end

    // offer one word, with an occasional idle burst in front
    task automatic send_word(input logic [31:0] value, input logic last);
        begin
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= value;
            s_tlast  <= last;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            sent_count++;
        end
    endtask

    // short list drawn mostly from a small pool so repeats are common
    task automatic send_short_list();
        logic [31:0] pool_base;
        logic [31:0] value;
        int          len;
        begin
            pool_base = $urandom;
            len       = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    value = $urandom;
                else
                    value = pool_base + $urandom_range(0, 7);
                send_word(value, i == len - 1);
            end
        end
    endtask

    // list that fills every slot, then pushes unseen values and repeats into a full store
    task automatic send_fill_list();
        logic [31:0] base;
        logic [31:0] stride;
        logic [31:0] value;
        int          extra;
        int          pick;
        begin
            base   = $urandom;
            stride = $urandom | 32'd1;
            for (int i = 0; i < dvf_pkg::CAPACITY; i++)
            begin
                if (i > 0 && $urandom_range(0, 5) == 0)
                begin
                    value = base + $urandom_range(0, i - 1) * stride;
                    send_word(value, 1'b0);
                end
                value = base + i * stride;
                send_word(value, 1'b0);
            end
            extra = $urandom_range(2, 10);
            for (int k = 0; k < extra; k++)
            begin
                pick = $urandom_range(0, 3);
                if (pick <= 1)
                    value = base + (dvf_pkg::CAPACITY + k) * stride;
                else if (pick == 2)
                    value = base + $urandom_range(0, dvf_pkg::CAPACITY - 1) * stride;
                else if ($urandom_range(0, 1) == 0)
                    value = base + (dvf_pkg::CAPACITY - 1) * stride;
                else
                    value = base;
                send_word(value, k == extra - 1);
            end
        end
    endtask

    // receiver: random stall bursts and one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                m_tready  <= 1'b0;
                hold_done <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // stimulus and verdict
    initial
    begin
        int  random_start;
        int  progress;
        bit  paused;

        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the value, repeats, single-bit differences
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        // repeat on the last word
        send_word(32'h8000_0000, 1'b1);
        // single-word list right after a clear
        send_word(32'h8000_0000, 1'b1);
        // unseen value on the last word
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0006, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b1);
        // value from the previous list is new again
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0005, 1'b1);

        // random lists, the first one fills the store and may run it into overflow
        random_start = sent_count;
        send_fill_list();
        progress = sent_count - random_start;
        while (progress < RANDOM_ITEMS)
        begin
            if (!hold_request && progress >= 150)
                hold_request <= 1'b1;
            if (!paused && progress >= 350)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
                paused = 1'b1;
            end
            if (progress >= 500)
                idle_en <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                send_fill_list();
            else
                send_short_list();
            progress = sent_count - random_start;
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** distinct_value_filter_top: PASSED **");
        else
            $display("** distinct_value_filter_top: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

FILE: distinct_value_filter_top.f
hw/rtl/dvf_pkg.sv
hw/rtl/dvf_ctrl.sv
hw/rtl/dvf_datapath.sv
hw/rtl/distinct_value_filter_top.sv
dv/distinct_value_filter_checker.sv
dv/tb_distinct_value_filter_top.sv
